// ===== hdl/can_bts_pkg.sv =====
package can_bts_pkg;

    // field widths
    localparam int CLOCK_W   = 29;
    localparam int RATE_W    = 20;
    localparam int QUANTA_W  = 5;
    localparam int PRESC_W   = 16;
    localparam int SEG1_W    = 5;
    localparam int SEG2_W    = 3;
    localparam int DIVISOR_W = RATE_W + QUANTA_W;
    localparam int DIV_CNT_W = $clog2(CLOCK_W);

    // trial search
    localparam int BASE_QUANTA = 16;
    localparam int MAX_OFFSET  = 9;
    localparam int N_TRIALS    = 2 * (MAX_OFFSET + 1);
    localparam int TRIAL_W     = $clog2(N_TRIALS);

    localparam logic [CLOCK_W-1:0] CLOCK_RESET = CLOCK_W'(36000000);

    // divider request and response
    typedef struct packed {
        logic                 start;
        logic [CLOCK_W-1:0]   dividend;
        logic [DIVISOR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [CLOCK_W-1:0]   quotient;
        logic [DIVISOR_W-1:0] remainder;
    } t_div_rsp;

    typedef struct packed {
        logic [SEG1_W-1:0] seg1;
        logic [SEG2_W-1:0] seg2;
    } t_seg;

    // trial order 16, 16, 15, 17, 14, 18 ... 7, 25
    function automatic logic [QUANTA_W-1:0] trial_quanta(input logic [TRIAL_W-1:0] k);
        logic [QUANTA_W-1:0] off;
        off = QUANTA_W'(k >> 1);
        if (k[0]) begin
            trial_quanta = QUANTA_W'(BASE_QUANTA) + off;
        end else begin
            trial_quanta = QUANTA_W'(BASE_QUANTA) - off;
        end
    endfunction

    // segment split for a quanta count, sample point nearest 7/8
    function automatic t_seg seg_split(input logic [QUANTA_W-1:0] q);
        logic [7:0]          tgt;
        logic [QUANTA_W-1:0] s1;
        logic [QUANTA_W-1:0] s2;
        logic [8:0]          a;
        logic [8:0]          b;
        logic [8:0]          da;
        logic [8:0]          db;
        tgt = 8'(q) * 8'd7;
        s1  = QUANTA_W'(tgt >> 3) - QUANTA_W'(1);
        a   = 9'({4'b0, s1} + 9'd2) << 3;
        b   = 9'({4'b0, s1} + 9'd1) << 3;
        da  = (a > {1'b0, tgt}) ? a - {1'b0, tgt} : {1'b0, tgt} - a;
        db  = (b > {1'b0, tgt}) ? b - {1'b0, tgt} : {1'b0, tgt} - b;
        if (da < db) begin
            s1 = s1 + QUANTA_W'(1);
        end
        s2 = q - s1 - QUANTA_W'(1);
        seg_split.seg1 = SEG1_W'(s1 - QUANTA_W'(1));
        seg_split.seg2 = SEG2_W'(s2 - QUANTA_W'(1));
    endfunction

endpackage

// ===== hdl/can_bit_timing_solver_unit.sv =====
// search: a zero bitrate skips the trials, else each quanta trial runs one divider pass,
//   up to 20 trials from accept to result
// flow: one item at a time, set by the shared 29-step serial divider,
//   the input reopens as the result is registered
// a result waits in the output register while the next item is accepted
// reset: synchronous active low, clock register to 36000000, control idle
module can_bit_timing_solver_unit
    import can_bts_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CLOCK_W-1:0]  i_cfg_clock_hz,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [RATE_W-1:0]   i_target_bitrate,
    output logic                o_valid,
    input  logic                i_stall,
    output logic                o_found,
    output logic [QUANTA_W-1:0] o_quanta_per_bit,
    output logic [PRESC_W-1:0]  o_prescaler,
    output logic [SEG1_W-1:0]   o_seg1_field,
    output logic [SEG2_W-1:0]   o_seg2_field
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_WAIT  = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [CLOCK_W-1:0]   r_clock_hz;
    logic [RATE_W-1:0]    r_rate;
    logic [TRIAL_W-1:0]   r_trial;
    logic [QUANTA_W-1:0]  r_q;
    logic [DIVISOR_W-1:0] r_divisor;
    logic                 r_found;
    logic [PRESC_W-1:0]   r_presc;
    logic                 r_out_valid;
    logic                 r_o_found;
    logic [QUANTA_W-1:0]  r_o_q;
    logic [PRESC_W-1:0]   r_o_presc;
    logic [SEG1_W-1:0]    r_o_seg1;
    logic [SEG2_W-1:0]    r_o_seg2;

    logic     in_acc;
    logic     out_load;
    logic     out_free;
    logic     hit;
    t_seg     seg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    assign o_cfg_ready = 1'b1;
    assign o_stall     = (r_state != S_IDLE);
    assign in_acc      = i_valid && !o_stall;
    assign out_free    = !r_out_valid || !i_stall;
    assign out_load    = (r_state == S_FIN) && out_free;
    assign hit         = (div_rsp.remainder == '0);
    assign seg         = seg_split(r_q);

    // clock frequency register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_clock_hz <= i_cfg_clock_hz;
        end
    end

    // shared divider
    always_comb begin
        div_req.start    = (r_state == S_START);
        div_req.dividend = r_clock_hz;
        div_req.divisor  = r_divisor;
    end

    can_bts_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // trial sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_target_bitrate == '0) ? S_FIN : S_MUL;
                end
            end
            S_MUL:   n_state = S_START;
            S_START: n_state = S_WAIT;
            S_WAIT: begin
                if (div_rsp.done) begin
                    if (hit || r_trial == TRIAL_W'(N_TRIALS - 1)) begin
                        n_state = S_FIN;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // trial datapath
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_rate  <= i_target_bitrate;
            r_trial <= '0;
            r_found <= 1'b0;
        end
        if (r_state == S_MUL) begin
            r_q       <= trial_quanta(r_trial);
            r_divisor <= DIVISOR_W'({{QUANTA_W{1'b0}}, r_rate}
                                    * {{RATE_W{1'b0}}, trial_quanta(r_trial)});
        end
        if (r_state == S_WAIT && div_rsp.done) begin
            r_trial <= r_trial + TRIAL_W'(1);
            if (hit) begin
                r_found <= 1'b1;
                r_presc <= div_rsp.quotient[PRESC_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_found <= r_found;
            r_o_q     <= r_found ? r_q       : '0;
            r_o_presc <= r_found ? r_presc   : '0;
            r_o_seg1  <= r_found ? seg.seg1  : '0;
            r_o_seg2  <= r_found ? seg.seg2  : '0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_found          = r_o_found;
    assign o_quanta_per_bit = r_o_q;
    assign o_prescaler      = r_o_presc;
    assign o_seg1_field     = r_o_seg1;
    assign o_seg2_field     = r_o_seg2;

    // zero bitrate skips the search
    a_zero_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_target_bitrate == '0) |=> (r_state == S_FIN))
        else $error("zero bitrate did not go straight to result");

    // a miss that is not the last trial starts the next one
    a_next_trial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WAIT && div_rsp.done && !hit
         && r_trial != TRIAL_W'(N_TRIALS - 1)) |=> (r_state == S_MUL))
        else $error("search stopped early");

    // a found result carries a count in range
    a_q_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_quanta_per_bit >= QUANTA_W'(7)
                                  && o_quanta_per_bit <= QUANTA_W'(25)))
        else $error("quanta count out of range");

    // no hit gives all-zero fields
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_quanta_per_bit == '0 && o_prescaler == '0
                                   && o_seg1_field == '0 && o_seg2_field == '0))
        else $error("miss result not cleared");

endmodule

// ===== hdl/can_bts_divider.sv =====
module can_bts_divider
    import can_bts_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIVISOR_W-1:0] r_rem;
    logic [CLOCK_W-1:0]   r_quo;
    logic [DIVISOR_W-1:0] r_dvs;

    logic [DIVISOR_W:0]   n_rem_sh;
    logic [DIVISOR_W+1:0] n_diff;
    logic                 n_ge;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb begin
        n_rem_sh = {r_rem, r_quo[CLOCK_W-1]};
        n_diff   = {1'b0, n_rem_sh} - {2'b00, r_dvs};
        n_ge     = !n_diff[DIVISOR_W+1];
    end

    // step control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(CLOCK_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient and remainder datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[DIVISOR_W-1:0] : n_rem_sh[DIVISOR_W-1:0];
            r_quo <= {r_quo[CLOCK_W-2:0], n_ge};
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule
